[design/tst_pkg.sv]
// ----------------------------------------------------------------------------
// tst_pkg: shared types and constants of the timer slot table
// Slot count, time width, command codes, FSM states and the slot record.
// ----------------------------------------------------------------------------
package tst_pkg;

  // Table geometry
  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 32;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W     = $clog2(SLOTS + 1);

  // Stream field widths
  localparam int FUNC_W   = 4;
  localparam int ID_W     = 5;
  localparam int AMOUNT_W = 32;
  localparam int VALUE_W  = 32;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SLOT_W-1:0]    slot_idx_t;
  typedef logic [CNT_W-1:0]     slot_cnt_t;

  // Command codes carried in the input tuser
  typedef enum logic [FUNC_W-1:0] {
    FN_TICK       = 4'd0,
    FN_TIMEOUT    = 4'd1,
    FN_INTERVAL   = 4'd2,
    FN_REMAINING  = 4'd3,
    FN_SET_DELAY  = 4'd4,
    FN_POSTPONE   = 4'd5,
    FN_RESTART    = 4'd6,
    FN_CANCEL     = 4'd7,
    FN_CANCEL_ALL = 4'd8
  } func_e;

  // Result kinds carried in the output tuser
  localparam logic KIND_FIRED = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CMD_EV,
    ST_REM,
    ST_SCAN,
    ST_FLUSH,
    ST_REPLY
  } state_e;

  // One slot record as kept in the slot memory
  typedef struct packed {
    logic  periodic;
    time_t start;
    time_t delay;
  } slot_ent_t;

endpackage

[design/timer_slot_table_core.sv]
// ----------------------------------------------------------------------------
// timer_slot_table_core: multi-channel one-shot / periodic timer table
// Slot records live in a synchronous memory with registered read; a sequencer
// runs the tick scan, cancel-all scan and per-slot read-modify-write commands.
//
// One item is taken at a time; s_axis_tready_o is high only while the
// sequencer is idle, and a finished result can still wait in the output
// register while the next item is taken. A tick with no live timer ends as
// it is taken. A tick with live timers, and a cancel-all, scan every slot
// through the slot memory's single read port, one slot per cycle with read
// and evaluate overlapped, except while a fired notice waits on an untaken
// result in the output register. Create and cancel execute and reply;
// set-delay, postpone and restart read the slot, write it back and reply;
// remaining reads, adds, compares and subtracts, and replies, but skips the
// compare and subtract on an inactive slot. A command with an id matching no
// slot, or an unused function code, goes from execute to reply. Replies wait
// while the output register holds an untaken result. Fired notices of one
// tick come in slot order, with tlast on the final one; every command gives
// a single reply with tlast set. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module timer_slot_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [4:0] timer_id, [36:5] amount,
                                        // [37] include_intervals, [39:38] zero
  input  logic [3:0]  s_axis_tuser_i,   // [3:0] func
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] result_value
  output logic [0:0]  m_axis_tuser_o,   // [0] result_kind
  output logic        m_axis_tlast_o    // last_of_run
);

  localparam int SLOTS  = tst_pkg::SLOTS;
  localparam int SLOT_W = tst_pkg::SLOT_W;
  localparam int CNT_W  = tst_pkg::CNT_W;
  localparam int VAL_W  = tst_pkg::VALUE_W;

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  tst_pkg::state_e    state_q, state_d;
  tst_pkg::time_t     now_q, now_d;
  logic [SLOTS-1:0]   active_q, active_d;
  tst_pkg::slot_idx_t stack_q [SLOTS];
  tst_pkg::slot_idx_t stack_d [SLOTS];
  tst_pkg::slot_cnt_t free_cnt_q, free_cnt_d;
  tst_pkg::slot_cnt_t live_cnt_q, live_cnt_d;

  // Latched command
  tst_pkg::func_e     func_q, func_d;
  logic               hit_q, hit_d;
  tst_pkg::slot_idx_t sel_q, sel_d;
  tst_pkg::time_t     amount_q, amount_d;
  logic               incl_q, incl_d;

  // Scan pipeline
  tst_pkg::slot_cnt_t rd_idx_q, rd_idx_d;
  logic               ev_v_q, ev_v_d;
  tst_pkg::slot_idx_t ev_idx_q, ev_idx_d;
  logic               pend_v_q, pend_v_d;
  tst_pkg::slot_idx_t pend_idx_q, pend_idx_d;

  tst_pkg::time_t     due_q, due_d;
  logic [VAL_W-1:0]   reply_q, reply_d;

  // Output register
  logic               out_v_q, out_v_d;
  logic               out_kind_q, out_kind_d;
  logic [VAL_W-1:0]   out_val_q, out_val_d;
  logic               out_last_q, out_last_d;

  // Slot memory
  tst_pkg::slot_ent_t slot_mem [SLOTS];
  tst_pkg::slot_ent_t mem_rdata_q;
  logic               mem_re, mem_we;
  tst_pkg::slot_idx_t mem_raddr, mem_waddr;
  tst_pkg::slot_ent_t mem_wdata;

  // Helpers
  logic               accept, out_free;
  logic               free_req;
  tst_pkg::slot_idx_t free_idx;
  tst_pkg::slot_cnt_t free_dec;
  tst_pkg::slot_idx_t new_slot;
  logic [4:0]         in_id;
  logic               in_hit;
  logic               start_gt, fire, stall, adv;
  tst_pkg::time_t     elapsed;

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  assign s_axis_tready_o = (state_q == tst_pkg::ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_id           = s_axis_tdata_i[4:0];
  assign in_hit          = (in_id != 5'd0) && (in_id <= SLOTS);
  assign out_free        = !out_v_q || m_axis_tready_i;

  assign free_dec = free_cnt_q - tst_pkg::slot_cnt_t'(1);
  assign new_slot = stack_q[free_dec[SLOT_W-1:0]];

  // Expiry test for the slot under evaluation
  assign start_gt = mem_rdata_q.start > now_q;
  assign elapsed  = now_q - mem_rdata_q.start;

  always_comb begin
    if (func_q == tst_pkg::FN_TICK) begin
      fire = active_q[ev_idx_q] && !start_gt && (elapsed >= mem_rdata_q.delay);
    end else begin
      fire = active_q[ev_idx_q] && (incl_q || !mem_rdata_q.periodic);
    end
  end

  // Hold evaluation while a fired notice cannot be handed to the output
  assign stall = (func_q == tst_pkg::FN_TICK) && ev_v_q && fire && pend_v_q && !out_free;
  assign adv   = !ev_v_q || !stall;

  // --------------------------------------------------------------------------
  // Next state and datapath
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    now_d      = now_q;
    active_d   = active_q;
    stack_d    = stack_q;
    free_cnt_d = free_cnt_q;
    live_cnt_d = live_cnt_q;
    func_d     = func_q;
    hit_d      = hit_q;
    sel_d      = sel_q;
    amount_d   = amount_q;
    incl_d     = incl_q;
    rd_idx_d   = rd_idx_q;
    ev_v_d     = ev_v_q;
    ev_idx_d   = ev_idx_q;
    pend_v_d   = pend_v_q;
    pend_idx_d = pend_idx_q;
    due_d      = due_q;
    reply_d    = reply_q;
    out_v_d    = out_v_q;
    out_kind_d = out_kind_q;
    out_val_d  = out_val_q;
    out_last_d = out_last_q;
    mem_re     = 1'b0;
    mem_raddr  = sel_q;
    mem_we     = 1'b0;
    mem_waddr  = sel_q;
    mem_wdata  = mem_rdata_q;
    free_req   = 1'b0;
    free_idx   = sel_q;

    // Drop a result the sink has taken
    if (out_v_q && m_axis_tready_i) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      tst_pkg::ST_IDLE: begin
        if (accept) begin
          func_d   = tst_pkg::func_e'(s_axis_tuser_i);
          hit_d    = in_hit;
          sel_d    = SLOT_W'(in_id - 5'd1);
          amount_d = tst_pkg::time_t'(s_axis_tdata_i[36:5]);
          incl_d   = s_axis_tdata_i[37];
          reply_d  = '0;
          rd_idx_d = '0;
          ev_v_d   = 1'b0;
          pend_v_d = 1'b0;
          if (tst_pkg::func_e'(s_axis_tuser_i) == tst_pkg::FN_TICK) begin
            now_d = now_q + tst_pkg::time_t'(1);
            if (live_cnt_q != '0) begin
              state_d = tst_pkg::ST_SCAN;
            end
          end else if (tst_pkg::func_e'(s_axis_tuser_i) == tst_pkg::FN_CANCEL_ALL) begin
            state_d = tst_pkg::ST_SCAN;
          end else begin
            state_d = tst_pkg::ST_EXEC;
          end
        end
      end

      tst_pkg::ST_EXEC: begin
        state_d = tst_pkg::ST_REPLY;
        case (func_q) inside
          tst_pkg::FN_TIMEOUT, tst_pkg::FN_INTERVAL: begin
            // Pop a free slot and write its whole record
            if (free_cnt_q != '0 && live_cnt_q < SLOTS) begin
              free_cnt_d         = free_dec;
              live_cnt_d         = live_cnt_q + tst_pkg::slot_cnt_t'(1);
              active_d[new_slot] = 1'b1;
              mem_we             = 1'b1;
              mem_waddr          = new_slot;
              mem_wdata.periodic = (func_q == tst_pkg::FN_INTERVAL);
              mem_wdata.start    = now_q;
              mem_wdata.delay    = amount_q;
              reply_d            = VAL_W'(new_slot) + VAL_W'(1);
            end
          end
          tst_pkg::FN_REMAINING, tst_pkg::FN_SET_DELAY,
          tst_pkg::FN_POSTPONE, tst_pkg::FN_RESTART: begin
            if (hit_q) begin
              mem_re  = 1'b1;
              state_d = tst_pkg::ST_CMD_EV;
            end
          end
          tst_pkg::FN_CANCEL: begin
            if (hit_q && active_q[sel_q]) begin
              free_req = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      tst_pkg::ST_CMD_EV: begin
        state_d = tst_pkg::ST_REPLY;
        case (func_q)
          tst_pkg::FN_REMAINING: begin
            if (active_q[sel_q]) begin
              due_d   = mem_rdata_q.start + mem_rdata_q.delay;
              state_d = tst_pkg::ST_REM;
            end
          end
          tst_pkg::FN_SET_DELAY: begin
            mem_we          = 1'b1;
            mem_wdata.delay = amount_q;
          end
          tst_pkg::FN_POSTPONE: begin
            mem_we          = 1'b1;
            mem_wdata.start = mem_rdata_q.start + amount_q;
          end
          tst_pkg::FN_RESTART: begin
            mem_we          = 1'b1;
            mem_wdata.start = now_q;
          end
          default: begin
          end
        endcase
      end

      tst_pkg::ST_REM: begin
        if (now_q < due_q) begin
          reply_d = VAL_W'(due_q - now_q);
        end
        state_d = tst_pkg::ST_REPLY;
      end

      tst_pkg::ST_SCAN: begin
        // Evaluate the slot whose record the read port last returned
        if (ev_v_q && !stall && fire) begin
          if (func_q == tst_pkg::FN_TICK) begin
            if (mem_rdata_q.periodic) begin
              mem_we          = 1'b1;
              mem_waddr       = ev_idx_q;
              mem_wdata.start = now_q;
            end else begin
              free_req = 1'b1;
              free_idx = ev_idx_q;
            end
            // Hand over the previous notice; it is not the last one
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_kind_d = tst_pkg::KIND_FIRED;
              out_val_d  = VAL_W'(pend_idx_q) + VAL_W'(1);
              out_last_d = 1'b0;
            end
            pend_v_d   = 1'b1;
            pend_idx_d = ev_idx_q;
          end else begin
            free_req = 1'b1;
            free_idx = ev_idx_q;
          end
        end
        // Advance the read side
        if (adv) begin
          if (rd_idx_q != CNT_W'(SLOTS)) begin
            mem_re    = 1'b1;
            mem_raddr = rd_idx_q[SLOT_W-1:0];
            ev_v_d    = 1'b1;
            ev_idx_d  = rd_idx_q[SLOT_W-1:0];
            rd_idx_d  = rd_idx_q + tst_pkg::slot_cnt_t'(1);
          end else begin
            ev_v_d = 1'b0;
            if (func_q == tst_pkg::FN_TICK) begin
              state_d = tst_pkg::ST_FLUSH;
            end else begin
              reply_d = '0;
              state_d = tst_pkg::ST_REPLY;
            end
          end
        end
      end

      tst_pkg::ST_FLUSH: begin
        // Emit the final notice of the tick with tlast
        if (!pend_v_q) begin
          state_d = tst_pkg::ST_IDLE;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_kind_d = tst_pkg::KIND_FIRED;
          out_val_d  = VAL_W'(pend_idx_q) + VAL_W'(1);
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = tst_pkg::ST_IDLE;
        end
      end

      tst_pkg::ST_REPLY: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_kind_d = tst_pkg::KIND_REPLY;
          out_val_d  = reply_q;
          out_last_d = 1'b1;
          state_d    = tst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tst_pkg::ST_IDLE;
      end
    endcase

    // Free one slot: clear it and push it onto the free stack
    if (free_req) begin
      active_d[free_idx] = 1'b0;
      if (live_cnt_q != '0) begin
        live_cnt_d = live_cnt_q - tst_pkg::slot_cnt_t'(1);
      end
      if (free_cnt_q < SLOTS) begin
        stack_d[free_cnt_q[SLOT_W-1:0]] = free_idx;
        free_cnt_d = free_cnt_q + tst_pkg::slot_cnt_t'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tst_pkg::ST_IDLE;
      now_q      <= '0;
      active_q   <= '0;
      free_cnt_q <= CNT_W'(SLOTS);
      live_cnt_q <= '0;
      ev_v_q     <= 1'b0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        stack_q[i] <= SLOT_W'(SLOTS - 1 - i);
      end
    end else begin
      state_q    <= state_d;
      now_q      <= now_d;
      active_q   <= active_d;
      free_cnt_q <= free_cnt_d;
      live_cnt_q <= live_cnt_d;
      ev_v_q     <= ev_v_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
      stack_q    <= stack_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    hit_q      <= hit_d;
    sel_q      <= sel_d;
    amount_q   <= amount_d;
    incl_q     <= incl_d;
    rd_idx_q   <= rd_idx_d;
    ev_idx_q   <= ev_idx_d;
    pend_idx_q <= pend_idx_d;
    due_q      <= due_d;
    reply_q    <= reply_d;
    out_kind_q <= out_kind_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  // --------------------------------------------------------------------------
  // Slot memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= slot_mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_val_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic [CNT_W:0] cnt_sum;
  assign cnt_sum = {1'b0, free_cnt_q} + {1'b0, live_cnt_q};

  a_count_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_sum == (CNT_W + 1)'(SLOTS))
    else $error("free and live counts do not add up to the slot count");

  a_live_matches_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_cnt_q == CNT_W'($countones(active_q)))
    else $error("live count differs from number of active slots");

  a_reply_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_kind_q == tst_pkg::KIND_REPLY) |-> out_last_q)
    else $error("command reply without tlast");

  a_no_write_on_read_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tst_pkg::ST_SCAN && mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("scan writes the slot it is reading");

endmodule

[tb/sv/tb_timer_slot_table_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timer_slot_table_core: self-checking bench for the timer slot table
// A short table of hand-picked commands, then random command traffic with
// bursts that fill the table, drive the core through its stream ports.
// A local copy of the slot table predicts every fired notice and reply, but
// the typed replies of directed rows; a monitor compares each result against
// the oldest prediction. Both sides idle at random until the closing stretch.
// ----------------------------------------------------------------------------
module tb_timer_slot_table_core;

  localparam int SLOTS    = tst_pkg::SLOTS;
  localparam int ID_W     = tst_pkg::ID_W;
  localparam int AMOUNT_W = tst_pkg::AMOUNT_W;
  localparam int VALUE_W  = tst_pkg::VALUE_W;

  localparam int unsigned RAND_ITEMS = 250;
  localparam int unsigned PLAN_ROWS  = 25;

  // One command as it travels on the input stream
  typedef struct {
    tst_pkg::func_e       func;
    logic [ID_W-1:0]      id;
    logic [AMOUNT_W-1:0]  amount;
    logic                 incl;
  } cmd_t;

  // One result as it travels on the output stream
  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } outcome_t;

  // Directed row: command plus an optional hand-written reply value
  typedef struct {
    tst_pkg::func_e       func;
    logic [ID_W-1:0]      id;
    logic [AMOUNT_W-1:0]  amount;
    logic                 incl;
    logic                 typed;
    logic [VALUE_W-1:0]   want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cmd_valid = 1'b0;
  logic [39:0] cmd_data = '0;
  logic [3:0]  cmd_user = '0;
  logic        res_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  bit          quiet = 1'b0;
  int unsigned err_cnt = 0;

  // Expected results in arrival order, and the results of the latest command
  outcome_t owed_outcomes[$];
  outcome_t step_outcomes[$];

  // Local copy of the slot table
  tst_pkg::time_t     clock_now;
  logic               slot_on     [SLOTS];
  logic               slot_rep    [SLOTS];
  logic               slot_t0_set [SLOTS];
  tst_pkg::time_t     slot_t0     [SLOTS];
  tst_pkg::time_t     slot_len    [SLOTS];
  tst_pkg::slot_idx_t spare_stack [SLOTS];
  int unsigned        spare_n;
  int unsigned        busy_n;

  plan_row_t plan [PLAN_ROWS] = '{
    '{tst_pkg::FN_REMAINING,  5'd1,  32'd0,          1'b0, 1'b1, 32'd0},
    '{tst_pkg::FN_TICK,       5'd0,  32'd0,          1'b0, 1'b0, 32'd0},
    '{tst_pkg::FN_CANCEL,     5'd0,  32'd0,          1'b0, 1'b1, 32'd0},
    '{tst_pkg::FN_TIMEOUT,    5'd0,  32'd0,          1'b0, 1'b1, 32'd1},
    '{tst_pkg::FN_INTERVAL,   5'd0,  32'd2,          1'b0, 1'b1, 32'd2},
    '{tst_pkg::FN_TIMEOUT,    5'd0,  32'hFFFF_FFFF,  1'b0, 1'b1, 32'd3},
    '{tst_pkg::FN_REMAINING,  5'd3,  32'd0,          1'b0, 1'b0, 32'd0},
    '{tst_pkg::FN_REMAINING,  5'd2,  32'd0,          1'b0, 1'b0, 32'd0},
    '{tst_pkg::FN_TICK,       5'd0,  32'd0,          1'b0, 1'b0, 32'd0},
    '{tst_pkg::FN_TICK,       5'd0,  32'd0,          1'b0, 1'b0, 32'd0},
    '{tst_pkg::FN_POSTPONE,   5'd2,  32'hFFFF_FFFF,  1'b0, 1'b1, 32'd0},
    '{tst_pkg::FN_SET_DELAY,  5'd3,  32'd1,          1'b0, 1'b1, 32'd0},
    '{tst_pkg::FN_RESTART,    5'd3,  32'd0,          1'b0, 1'b1, 32'd0},
    '{tst_pkg::FN_TICK,       5'd0,  32'd0,          1'b0, 1'b0, 32'd0},
    '{tst_pkg::FN_POSTPONE,   5'd2,  32'd100,        1'b0, 1'b1, 32'd0},
    '{tst_pkg::FN_TICK,       5'd0,  32'd0,          1'b0, 1'b0, 32'd0},
    '{tst_pkg::FN_REMAINING,  5'd2,  32'd0,          1'b0, 1'b0, 32'd0},
    '{tst_pkg::FN_REMAINING,  5'd16, 32'd0,          1'b0, 1'b1, 32'd0},
    '{tst_pkg::FN_REMAINING,  5'd0,  32'd0,          1'b0, 1'b1, 32'd0},
    '{tst_pkg::FN_TIMEOUT,    5'd0,  32'd1,          1'b0, 1'b0, 32'd0},
    '{tst_pkg::FN_CANCEL_ALL, 5'd0,  32'd0,          1'b0, 1'b1, 32'd0},
    '{tst_pkg::FN_REMAINING,  5'd2,  32'd0,          1'b0, 1'b0, 32'd0},
    '{tst_pkg::FN_CANCEL_ALL, 5'd0,  32'd0,          1'b1, 1'b1, 32'd0},
    '{tst_pkg::FN_CANCEL,     5'd2,  32'd0,          1'b0, 1'b1, 32'd0},
    '{tst_pkg::FN_SET_DELAY,  5'd16, 32'hFFFF_FFFF,  1'b1, 1'b1, 32'd0}
  };

  timer_slot_table_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (cmd_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (cmd_data),
    .s_axis_tuser_i  (cmd_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Put the local table into its reset state
  function automatic void table_clear();
    clock_now = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_on[i]     = 1'b0;
      slot_rep[i]    = 1'b0;
      slot_t0_set[i] = 1'b0;
      slot_t0[i]     = '0;
      slot_len[i]    = '0;
      spare_stack[i] = tst_pkg::slot_idx_t'(SLOTS - 1 - i);
    end
    spare_n = SLOTS;
    busy_n  = 0;
  endfunction

  // Deactivate a slot and return it to the free stack
  function automatic void slot_release(int unsigned s);
    slot_on[s] = 1'b0;
    if (busy_n > 0) busy_n--;
    if (spare_n < SLOTS) begin
      spare_stack[spare_n] = tst_pkg::slot_idx_t'(s);
      spare_n++;
    end
  endfunction

  // Apply one command to the local table and collect the results it causes
  function automatic void table_advance(cmd_t c);
    logic               hit;
    int unsigned        s;
    int unsigned        t;
    tst_pkg::time_t     due;
    logic [VALUE_W-1:0] value;
    hit   = (c.id >= 1) && (c.id <= SLOTS);
    s     = hit ? c.id - 1 : 0;
    value = '0;
    step_outcomes.delete();
    if (c.func == tst_pkg::FN_TICK) begin
      clock_now = clock_now + 1'b1;
      if (busy_n != 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_on[i] && !(slot_t0[i] > clock_now) &&
              (tst_pkg::time_t'(clock_now - slot_t0[i]) >= slot_len[i])) begin
            if (slot_rep[i]) slot_t0[i] = clock_now;
            else slot_release(i);
            step_outcomes.push_back('{tst_pkg::KIND_FIRED, VALUE_W'(i + 1), 1'b0});
          end
        end
      end
      if (step_outcomes.size() != 0) step_outcomes[step_outcomes.size() - 1].last = 1'b1;
      return;
    end
    case (c.func) inside
      tst_pkg::FN_TIMEOUT, tst_pkg::FN_INTERVAL: begin
        if (spare_n > 0 && busy_n < SLOTS) begin
          spare_n--;
          t = spare_stack[spare_n];
          slot_rep[t]    = (c.func == tst_pkg::FN_INTERVAL);
          slot_len[t]    = c.amount;
          slot_t0[t]     = clock_now;
          slot_t0_set[t] = 1'b1;
          slot_on[t]     = 1'b1;
          busy_n++;
          value = VALUE_W'(t + 1);
        end
      end
      tst_pkg::FN_REMAINING: begin
        if (hit && slot_on[s]) begin
          due = slot_t0[s] + slot_len[s];
          if (clock_now < due) value = VALUE_W'(due - clock_now);
        end
      end
      tst_pkg::FN_SET_DELAY: if (hit) slot_len[s] = c.amount;
      tst_pkg::FN_POSTPONE:  if (hit) slot_t0[s] = slot_t0[s] + c.amount;
      tst_pkg::FN_RESTART: begin
        if (hit) begin
          slot_t0[s]     = clock_now;
          slot_t0_set[s] = 1'b1;
        end
      end
      tst_pkg::FN_CANCEL: if (hit && slot_on[s]) slot_release(s);
      tst_pkg::FN_CANCEL_ALL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_on[i] && (c.incl || !slot_rep[i])) slot_release(i);
        end
      end
      default: ;
    endcase
    step_outcomes.push_back('{tst_pkg::KIND_REPLY, value, 1'b1});
  endfunction

  // Mostly short delays so timers expire within the run
  function automatic logic [AMOUNT_W-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 8) return AMOUNT_W'($urandom_range(0, 6));
    if (r == 8) return AMOUNT_W'($urandom);
    return {AMOUNT_W{1'b1}} - AMOUNT_W'($urandom_range(0, 3));
  endfunction

  // Prefer ids of live slots, else any id including the null one
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned on_list[$];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_on[i]) on_list.push_back(i);
    end
    if (on_list.size() != 0 && $urandom_range(0, 3) != 0)
      return ID_W'(on_list[$urandom_range(0, on_list.size() - 1)] + 1);
    return ID_W'($urandom_range(0, SLOTS));
  endfunction

  // Random command with a weighted mix of functions
  function automatic cmd_t rand_cmd();
    cmd_t        c;
    int unsigned r;
    c.func   = tst_pkg::FN_TICK;
    c.id     = ID_W'($urandom_range(0, SLOTS));
    c.amount = AMOUNT_W'($urandom);
    c.incl   = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 35) begin
      c.func = tst_pkg::FN_TICK;
    end else if (r < 50) begin
      c.func   = tst_pkg::FN_TIMEOUT;
      c.amount = pick_delay();
    end else if (r < 58) begin
      c.func   = tst_pkg::FN_INTERVAL;
      c.amount = pick_delay();
    end else if (r < 66) begin
      c.func = tst_pkg::FN_REMAINING;
      c.id   = pick_id();
    end else if (r < 72) begin
      c.func   = tst_pkg::FN_SET_DELAY;
      c.id     = pick_id();
      c.amount = pick_delay();
    end else if (r < 78) begin
      c.func   = tst_pkg::FN_POSTPONE;
      c.id     = pick_id();
      c.amount = pick_delay();
      // postpone must not read a start time that was never written
      if (c.id >= 1 && c.id <= SLOTS && !slot_t0_set[c.id - 1]) c.func = tst_pkg::FN_RESTART;
    end else if (r < 84) begin
      c.func = tst_pkg::FN_RESTART;
      c.id   = pick_id();
    end else if (r < 94) begin
      c.func = tst_pkg::FN_CANCEL;
      c.id   = pick_id();
    end else begin
      c.func = tst_pkg::FN_CANCEL_ALL;
    end
    return c;
  endfunction

  // Send one command, predict its results once the transaction is taken
  task automatic issue_cmd(input cmd_t c, input logic typed, input logic [VALUE_W-1:0] want);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= {2'b00, c.incl, c.amount, c.id};
    cmd_user  <= c.func;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    table_advance(c);
    if (typed) owed_outcomes.push_back('{tst_pkg::KIND_REPLY, want, 1'b1});
    else foreach (step_outcomes[k]) owed_outcomes.push_back(step_outcomes[k]);
  endtask

  // Hold the input idle until every expected result has come out
  task automatic settle();
    cmd_valid <= 1'b0;
    while (owed_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Result side backpressure: ready runs with random stall bursts
  initial begin
    forever begin
      res_ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 60)) @(posedge clk_i);
      else repeat ($urandom_range(1, 8)) @(posedge clk_i);
      if (!quiet) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  // Check each result transaction against the oldest expectation
  outcome_t want_q;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && res_ready) begin
      if (owed_outcomes.size() == 0) begin
        $error("unexpected result: kind %0d value %0d last %0d",
               m_axis_tuser_o[0], m_axis_tdata_o, m_axis_tlast_o);
        err_cnt++;
      end else begin
        want_q = owed_outcomes.pop_front();
        if (m_axis_tuser_o[0] !== want_q.kind) begin
          $error("result_kind: expected %0d, actual %0d", want_q.kind, m_axis_tuser_o[0]);
          err_cnt++;
        end
        if (m_axis_tdata_o !== want_q.value) begin
          $error("result_value: expected %0d, actual %0d", want_q.value, m_axis_tdata_o);
          err_cnt++;
        end
        if (m_axis_tlast_o !== want_q.last) begin
          $error("last_of_run: expected %0d, actual %0d", want_q.last, m_axis_tlast_o);
          err_cnt++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, random traffic, drain and verdict
  initial begin
    cmd_t        c;
    int unsigned sent_n;
    int unsigned fill_n;
    bit          mid_done;
    sent_n   = 0;
    mid_done = 1'b0;
    table_clear();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed commands
    foreach (plan[k]) begin
      c.func   = plan[k].func;
      c.id     = plan[k].id;
      c.amount = plan[k].amount;
      c.incl   = plan[k].incl;
      issue_cmd(c, plan[k].typed, plan[k].want);
    end
    settle();

    // Random commands, with occasional bursts that fill the table past full
    while (sent_n < RAND_ITEMS) begin
      if (sent_n >= RAND_ITEMS - 40) quiet = 1'b1;
      if ($urandom_range(0, 24) == 0) begin
        fill_n = spare_n + 1;
        repeat (fill_n) begin
          c.func   = $urandom_range(0, 1) ? tst_pkg::FN_INTERVAL : tst_pkg::FN_TIMEOUT;
          c.id     = ID_W'($urandom_range(0, SLOTS));
          c.amount = AMOUNT_W'($urandom_range(0, 3));
          c.incl   = 1'($urandom_range(0, 1));
          issue_cmd(c, 1'b0, '0);
          sent_n++;
        end
      end else begin
        issue_cmd(rand_cmd(), 1'b0, '0);
        sent_n++;
      end
      if (!mid_done && sent_n >= RAND_ITEMS / 2) begin
        mid_done = 1'b1;
        settle();
      end
    end

    settle();
    repeat (4 * SLOTS) @(posedge clk_i);
    if (err_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
